// ===== hw/rtl/emhq_pkg.sv =====
// ----------------------------------------------------------------------------
// emhq_pkg: shared types and codes for the edge min-heap queue
// Controller states, command and status bundles, result status codes.
// ----------------------------------------------------------------------------
package emhq_pkg;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_RM_RD,
		S_RM_TAKE,
		S_DN_RD,
		S_DN_CMP,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic place;
		logic rd_up;
		logic step_up;
		logic rd_rem;
		logic take;
		logic rd_dn;
		logic step_dn;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic full;
		logic empty;
		logic up_top;
		logic up_stop;
		logic dn_leaf;
		logic dn_stop;
	} sts_t;

endpackage

// ===== hw/rtl/emhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// emhq_ctrl: sequencer for the edge min-heap queue
// Walks insert sift-up and remove sift-down as read/compare pairs per level.
// ----------------------------------------------------------------------------
module emhq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  emhq_pkg::sts_t  sts,
	output emhq_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done
);

	emhq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= emhq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			emhq_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					if (sts.op == emhq_pkg::OP_INSERT && !sts.full) begin
						state_d = emhq_pkg::S_UP_RD;
					end else if (sts.op == emhq_pkg::OP_REMOVE && !sts.empty) begin
						state_d = emhq_pkg::S_RM_RD;
					end else begin
						state_d = emhq_pkg::S_EMIT;
					end
				end
			end
			emhq_pkg::S_UP_RD: begin
				if (sts.up_top) begin
					cmd.place = 1'b1;
					state_d   = emhq_pkg::S_EMIT;
				end else begin
					cmd.rd_up = 1'b1;
					state_d   = emhq_pkg::S_UP_CMP;
				end
			end
			emhq_pkg::S_UP_CMP: begin
				cmd.step_up = 1'b1;
				state_d     = sts.up_stop ? emhq_pkg::S_EMIT : emhq_pkg::S_UP_RD;
			end
			emhq_pkg::S_RM_RD: begin
				cmd.rd_rem = 1'b1;
				state_d    = emhq_pkg::S_RM_TAKE;
			end
			emhq_pkg::S_RM_TAKE: begin
				cmd.take = 1'b1;
				state_d  = emhq_pkg::S_DN_RD;
			end
			emhq_pkg::S_DN_RD: begin
				if (sts.dn_leaf) begin
					cmd.place = 1'b1;
					state_d   = emhq_pkg::S_EMIT;
				end else begin
					cmd.rd_dn = 1'b1;
					state_d   = emhq_pkg::S_DN_CMP;
				end
			end
			emhq_pkg::S_DN_CMP: begin
				cmd.step_dn = 1'b1;
				state_d     = sts.dn_stop ? emhq_pkg::S_EMIT : emhq_pkg::S_DN_RD;
			end
			emhq_pkg::S_EMIT: begin
				done    = 1'b1;
				state_d = emhq_pkg::S_IDLE;
			end
			default: begin
				state_d = emhq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/emhq_dpath.sv =====
// ----------------------------------------------------------------------------
// emhq_dpath: heap memory, entry count and sift datapath
// The moving entry is held in a register; each level writes one slot.
// ----------------------------------------------------------------------------
module emhq_dpath #(
	parameter int CAPACITY    = 64,
	parameter int VERTEX_BITS = 8,
	parameter int KEY_BITS    = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  emhq_pkg::cmd_t                     cmd,
	output emhq_pkg::sts_t                     sts,
	input  logic                               operation,
	input  logic [KEY_BITS-1:0]                edge_weight,
	input  logic [VERTEX_BITS-1:0]             edge_source,
	input  logic [VERTEX_BITS-1:0]             edge_target,
	output logic [1:0]                         status,
	output logic [KEY_BITS-1:0]                out_weight,
	output logic [VERTEX_BITS-1:0]             out_source,
	output logic [VERTEX_BITS-1:0]             out_target,
	output logic [$clog2(CAPACITY+1)-1:0]      fill_level
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int EW     = KEY_BITS + 2 * VERTEX_BITS;

	logic [EW-1:0]     mem [CAPACITY];
	logic [EW-1:0]     rd0_q, rd1_q, x_q;
	logic [CNT_W-1:0]  count_q, pos_q;
	logic [1:0]        status_q;
	logic [EW-1:0]     out_q;

	logic              we;
	logic [ADDR_W-1:0] wa, ra0, ra1;
	logic [EW-1:0]     wd;

	logic [CNT_W:0]    left_idx, right_idx, cnt_ext;
	logic [CNT_W-1:0]  parent_idx, pos_m1, cnt_m1, left_m1;
	logic              right_ok, pick_right;
	logic [EW-1:0]     child;
	logic [CNT_W:0]    child_idx;
	logic [KEY_BITS-1:0] x_key, k0, k1, child_key;

	assign x_key      = x_q[EW-1 -: KEY_BITS];
	assign k0         = rd0_q[EW-1 -: KEY_BITS];
	assign k1         = rd1_q[EW-1 -: KEY_BITS];
	assign cnt_ext    = {1'b0, count_q};
	assign left_idx   = {pos_q, 1'b0};
	assign right_idx  = left_idx + 1'b1;
	assign parent_idx = pos_q >> 1;
	assign pos_m1     = pos_q - 1'b1;
	assign cnt_m1     = count_q - 1'b1;
	assign left_m1    = left_idx[CNT_W-1:0] - 1'b1;
	assign right_ok   = right_idx <= cnt_ext;
	assign pick_right = right_ok && (k0 > k1);
	assign child      = pick_right ? rd1_q : rd0_q;
	assign child_idx  = pick_right ? right_idx : left_idx;
	assign child_key  = child[EW-1 -: KEY_BITS];

	assign sts.op      = operation;
	assign sts.full    = count_q == CNT_W'(CAPACITY);
	assign sts.empty   = count_q == '0;
	assign sts.up_top  = pos_q == CNT_W'(1);
	assign sts.up_stop = k0 < x_key;
	assign sts.dn_leaf = left_idx > cnt_ext;
	assign sts.dn_stop = x_key < child_key;

	// memory ports
	always_comb begin
		we  = cmd.place | cmd.step_up | cmd.step_dn;
		wa  = pos_m1[ADDR_W-1:0];
		wd  = x_q;
		if (cmd.step_up && !sts.up_stop) begin
			wd = rd0_q;
		end else if (cmd.step_dn && !sts.dn_stop) begin
			wd = child;
		end
		ra0 = '0;
		ra1 = '0;
		if (cmd.rd_up) begin
			ra0 = ADDR_W'(parent_idx - 1'b1);
		end else if (cmd.rd_rem) begin
			ra1 = cnt_m1[ADDR_W-1:0];
		end else if (cmd.rd_dn) begin
			ra0 = left_m1[ADDR_W-1:0];
			ra1 = left_idx[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			if (cmd.capture && operation == emhq_pkg::OP_INSERT && !sts.full) begin
				count_q <= count_q + 1'b1;
				pos_q   <= count_q + 1'b1;
			end else if (cmd.take) begin
				count_q <= cnt_m1;
				pos_q   <= CNT_W'(1);
			end else if (cmd.step_up && !sts.up_stop) begin
				pos_q <= parent_idx;
			end else if (cmd.step_dn && !sts.dn_stop) begin
				pos_q <= child_idx[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q   <= {edge_weight, edge_source, edge_target};
			out_q <= '0;
			if (operation == emhq_pkg::OP_INSERT) begin
				status_q <= sts.full ? emhq_pkg::ST_FULL : emhq_pkg::ST_DONE;
			end else begin
				status_q <= sts.empty ? emhq_pkg::ST_EMPTY : emhq_pkg::ST_DONE;
			end
		end else if (cmd.take) begin
			out_q <= rd0_q;
			x_q   <= rd1_q;
		end
	end

	assign status     = status_q;
	assign out_weight = out_q[EW-1 -: KEY_BITS];
	assign out_source = out_q[2*VERTEX_BITS-1 -: VERTEX_BITS];
	assign out_target = out_q[VERTEX_BITS-1:0];
	assign fill_level = count_q;

endmodule

// ===== hw/rtl/edge_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// edge_min_heap_queue: binary min-heap priority queue of weighted edges
// Insert or remove-min per request; one result strobe per request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on the result ports for exactly one cycle with done high, and cannot be
// held off. One request is in flight at a time. Every heap level that a walk
// compares (at most log2 of CAPACITY) costs a registered memory read and a
// compare-and-write step; a walk that stops on a compare writes the moving
// entry there and needs no final placement. A rejected request goes straight
// from acceptance to its result. The heap contents are not cleared at reset.
module edge_min_heap_queue #(
	parameter int CAPACITY    = 64,
	parameter int VERTEX_BITS = 8,
	parameter int KEY_BITS    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [KEY_BITS-1:0]           edge_weight,
	input  logic [VERTEX_BITS-1:0]        edge_source,
	input  logic [VERTEX_BITS-1:0]        edge_target,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [KEY_BITS-1:0]           out_weight,
	output logic [VERTEX_BITS-1:0]        out_source,
	output logic [VERTEX_BITS-1:0]        out_target,
	output logic [$clog2(CAPACITY+1)-1:0] fill_level
);

	emhq_pkg::cmd_t cmd;
	emhq_pkg::sts_t sts;

	emhq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	emhq_dpath #(
		.CAPACITY    (CAPACITY),
		.VERTEX_BITS (VERTEX_BITS),
		.KEY_BITS    (KEY_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.edge_weight (edge_weight),
		.edge_source (edge_source),
		.edge_target (edge_target),
		.status      (status),
		.out_weight  (out_weight),
		.out_source  (out_source),
		.out_target  (out_target),
		.fill_level  (fill_level)
	);

`ifndef ASSERT_OFF
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a request");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == emhq_pkg::ST_FULL) |->
		(fill_level == ($clog2(CAPACITY+1))'(CAPACITY) && out_weight == '0))
		else $error("full insert reported wrong level");

	a_empty_level: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == emhq_pkg::ST_EMPTY) |-> (fill_level == '0 && out_weight == '0))
		else $error("empty remove reported wrong level");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
`endif

endmodule
